// File: rtl/core/nplod_pkg.sv
// ----------------------------------------------------------------------------
// nplod_pkg
// Shared types and codes of the nearest point level-of-detail scale unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nplod_pkg;

  // field widths fixed by the interface
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SCALE_W  = 32;
  localparam int HELD_W   = 5;
  localparam int SIZE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W     = 2;

  // request codes on req_type
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z = 2'd2;

  localparam logic [SIZE_W-1:0] CHUNK_RESET = 16'd16;

  // decoded operation handed from front to back
  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_NOP
  } op_t;

  // one result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
    logic [SCALE_W-1:0]  scale_z;
    logic [HELD_W-1:0]   held;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/nearest_point_lod_scale_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_lod_scale_unit
// Point table giving per-axis level-of-detail scales for chunks.
// ----------------------------------------------------------------------------
// Requests enter through a push/full queue and each gives exactly one result
// on the empty/pop side, in order. A front end decodes requests into a
// two-entry command queue; the back end executes one command at a time and
// writes a two-entry result queue. An add, a no-op or a query on an empty
// table gives its result straight from the idle state. A remove walks the
// table one entry per cycle through its single read port and rewrites the
// surviving points. A query walks the table in the same manner into a
// distance pipeline, then three restoring dividers run side by side, each
// giving one quotient bit per cycle. Chunk sizes are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while no transaction
// is in flight, as the block itself does not enforce it; a size of zero
// divides by one. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_lod_scale_unit #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [nplod_pkg::REQ_W-1:0]           req_type,
  input  logic signed [COORD_BITS-1:0]          point_x,
  input  logic signed [COORD_BITS-1:0]          point_y,
  input  logic signed [COORD_BITS-1:0]          point_z,
  input  logic signed [COORD_BITS-1:0]          corner_x,
  input  logic signed [COORD_BITS-1:0]          corner_y,
  input  logic signed [COORD_BITS-1:0]          corner_z,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [nplod_pkg::STATUS_W-1:0]        status,
  output logic [nplod_pkg::SCALE_W-1:0]         scale_x,
  output logic [nplod_pkg::SCALE_W-1:0]         scale_y,
  output logic [nplod_pkg::SCALE_W-1:0]         scale_z,
  output logic [nplod_pkg::HELD_W-1:0]          points_held,
  input  logic                                  cfg_we,
  input  logic [nplod_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [nplod_pkg::SIZE_W-1:0]          cfg_wdata
);

  localparam int CMD_W = nplod_pkg::OP_W + 3 * COORD_BITS;
  localparam int RES_W = $bits(nplod_pkg::res_t);

  logic [nplod_pkg::SIZE_W-1:0] chunk_x;
  logic [nplod_pkg::SIZE_W-1:0] chunk_y;
  logic [nplod_pkg::SIZE_W-1:0] chunk_z;
  logic                         cmd_valid;
  logic [CMD_W-1:0]             cmd_data;
  logic                         cmd_pop;
  logic                         res_full;
  logic                         res_push;
  nplod_pkg::res_t              res;
  logic [RES_W-1:0]             head_bits;
  nplod_pkg::res_t              head;

  // chunk size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x <= nplod_pkg::CHUNK_RESET;
      chunk_y <= nplod_pkg::CHUNK_RESET;
      chunk_z <= nplod_pkg::CHUNK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        nplod_pkg::CFG_CHUNK_X: chunk_x <= cfg_wdata;
        nplod_pkg::CFG_CHUNK_Y: chunk_y <= cfg_wdata;
        nplod_pkg::CFG_CHUNK_Z: chunk_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request decode and command queue
  nplod_front #(
    .CW    (COORD_BITS),
    .CMD_W (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .corner_x  (corner_x),
    .corner_y  (corner_y),
    .corner_z  (corner_z),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  // table and search engine
  nplod_back #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .chunk_x   (chunk_x),
    .chunk_y   (chunk_y),
    .chunk_z   (chunk_z),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  nplod_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (head_bits),
    .full  (res_full),
    .empty (empty)
  );

  assign head        = nplod_pkg::res_t'(head_bits);
  assign status      = head.status;
  assign scale_x     = head.scale_x;
  assign scale_y     = head.scale_y;
  assign scale_z     = head.scale_z;
  assign points_held = head.held;

endmodule

`default_nettype wire

// File: rtl/core/nplod_fifo.sv
// ----------------------------------------------------------------------------
// nplod_fifo
// Small synchronous queue used between the unit's stages and on its output.
// ----------------------------------------------------------------------------
`default_nettype none

module nplod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : AW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : AW'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= (AW+1)'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= (AW+1)'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nplod_front.sv
// ----------------------------------------------------------------------------
// nplod_front
// Accepts request transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nplod_front #(
  parameter int CW    = 16,
  parameter int CMD_W = nplod_pkg::OP_W + 3 * CW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [nplod_pkg::REQ_W-1:0]    req_type,
  input  logic [CW-1:0]                  point_x,
  input  logic [CW-1:0]                  point_y,
  input  logic [CW-1:0]                  point_z,
  input  logic [CW-1:0]                  corner_x,
  input  logic [CW-1:0]                  corner_y,
  input  logic [CW-1:0]                  corner_z,
  output logic                           cmd_valid,
  output logic [CMD_W-1:0]               cmd_data,
  input  logic                           cmd_pop
);

  typedef struct packed {
    nplod_pkg::op_t op;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  z;
  } cmd_t;

  cmd_t cmd_in;
  logic q_empty;

  // classify the request and pick the coordinates it works on
  always_comb begin
    cmd_in.x = point_x;
    cmd_in.y = point_y;
    cmd_in.z = point_z;
    case (req_type)
      nplod_pkg::REQ_ADD:    cmd_in.op = nplod_pkg::OP_ADD;
      nplod_pkg::REQ_REMOVE: cmd_in.op = nplod_pkg::OP_REMOVE;
      nplod_pkg::REQ_QUERY: begin
        cmd_in.op = nplod_pkg::OP_QUERY;
        cmd_in.x  = corner_x;
        cmd_in.y  = corner_y;
        cmd_in.z  = corner_z;
      end
      default:               cmd_in.op = nplod_pkg::OP_NOP;
    endcase
  end

  // command queue toward the back end
  nplod_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .full  (full),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

// File: rtl/core/nplod_div.sv
// ----------------------------------------------------------------------------
// nplod_div
// Restoring divider, one quotient bit per cycle, with clamped scale output.
// ----------------------------------------------------------------------------
`default_nettype none

module nplod_div #(
  parameter int DW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [DW-1:0]                    dividend,
  input  logic [nplod_pkg::SIZE_W-1:0]     divisor,
  output logic                             done,
  output logic [nplod_pkg::SCALE_W-1:0]    scale
);

  localparam int SW = nplod_pkg::SIZE_W;
  localparam int QW = nplod_pkg::SCALE_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [DW-1:0]    quo;
  logic [SW-1:0]    rem;
  logic [SW-1:0]    dsr;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic [SW:0]      trial;
  logic             qbit;
  logic             ovf;
  logic [QW-1:0]    qlo;

  // one restoring step
  assign trial = {rem, dvd[DW-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  // clamp to [1, 2^32-1]
  assign ovf   = |(quo >> QW);
  assign qlo   = QW'(quo);
  assign scale = ovf ? '1 : ((qlo == '0) ? QW'(1) : qlo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(DW);
        dvd   <= dividend;
        quo   <= '0;
        rem   <= '0;
        dsr   <= (divisor == '0) ? SW'(1) : divisor;
      end else if (busy) begin
        rem   <= qbit ? SW'(trial - {1'b0, dsr}) : SW'(trial);
        quo   <= {quo[DW-2:0], qbit};
        dvd   <= {dvd[DW-2:0], 1'b0};
        steps <= CNT_W'(steps - 1'b1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nplod_back.sv
// ----------------------------------------------------------------------------
// nplod_back
// Point table, remove compaction walk, nearest point search and scale divide.
// ----------------------------------------------------------------------------
`default_nettype none

module nplod_back #(
  parameter int MAX_POINTS = 16,
  parameter int CW         = 16,
  parameter int CMD_W      = nplod_pkg::OP_W + 3 * CW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic [CMD_W-1:0]             cmd_data,
  output logic                         cmd_pop,
  input  logic [nplod_pkg::SIZE_W-1:0] chunk_x,
  input  logic [nplod_pkg::SIZE_W-1:0] chunk_y,
  input  logic [nplod_pkg::SIZE_W-1:0] chunk_z,
  input  logic                         res_full,
  output logic                         res_push,
  output nplod_pkg::res_t              res
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int HW    = nplod_pkg::HELD_W;

  typedef struct packed {
    nplod_pkg::op_t op;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  z;
  } cmd_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_QUERY,
    S_DIVIDE
  } state_t;

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  cmd_t             cmd;
  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] iss;
  logic [CNT_W-1:0] keep;
  ent_t             target;

  // point table
  ent_t             mem [MAX_POINTS];
  ent_t             rd_data;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ent_t             mem_wdata;
  logic             rd_v;

  // distance pipeline
  logic             va, vb, vc;
  logic [CW-1:0]    ad_x, ad_y, ad_z;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [SQ_W-1:0]  cx, cy, cz;
  logic [SUM_W-1:0] sum;
  logic [CMP_W-1:0] dcmp;
  logic             dovf;
  logic             have;
  logic [CMP_W-1:0] best;
  logic [SQ_W-1:0]  bx, by, bz;

  // dividers
  logic                          div_start;
  logic [2:0]                    div_done;
  logic [nplod_pkg::SCALE_W-1:0] div_x, div_y, div_z;

  assign cmd     = cmd_t'(cmd_data);
  assign cmd_pop = (state == S_IDLE) && cmd_valid && !res_full && !res_push;
  assign mem_re  = ((state == S_REMOVE) || (state == S_QUERY)) && (iss < count);

  // saturated distance sum for the compare
  assign dovf = |(sum >> CMP_W);
  assign dcmp = dovf ? '1 : sum[CMP_W-1:0];

  // table write port: append on add, compaction on remove
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = '{x: cmd.x, y: cmd.y, z: cmd.z};
    if (cmd_pop && (cmd.op == nplod_pkg::OP_ADD) && (count < CNT_W'(MAX_POINTS))) begin
      mem_we = 1'b1;
    end else if ((state == S_REMOVE) && rd_v && (rd_data != target)) begin
      mem_we    = 1'b1;
      mem_waddr = keep[IDX_W-1:0];
      mem_wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[iss[IDX_W-1:0]];
    end
  end

  // distance datapath: abs diff, square, sum
  always_ff @(posedge clk) begin
    ad_x <= absdiff(rd_data.x, target.x);
    ad_y <= absdiff(rd_data.y, target.y);
    ad_z <= absdiff(rd_data.z, target.z);
    sq_x <= SQ_W'(ad_x) * SQ_W'(ad_x);
    sq_y <= SQ_W'(ad_y) * SQ_W'(ad_y);
    sq_z <= SQ_W'(ad_z) * SQ_W'(ad_z);
    sum  <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    cx   <= sq_x;
    cy   <= sq_y;
    cz   <= sq_z;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_v      <= 1'b0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      have      <= 1'b0;
      res_push  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      res_push  <= 1'b0;
      div_start <= 1'b0;
      rd_v      <= mem_re;
      va        <= rd_v && (state == S_QUERY);
      vb        <= va;
      vc        <= vb;
      if (mem_re) begin
        iss <= CNT_W'(iss + 1'b1);
      end

      // nearest point tracking, earliest entry wins ties
      if (vc && (!have || (dcmp < best))) begin
        have <= 1'b1;
        best <= dcmp;
        bx   <= cx;
        by   <= cy;
        bz   <= cz;
      end

      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            res.status  <= nplod_pkg::ST_OK;
            res.scale_x <= '0;
            res.scale_y <= '0;
            res.scale_z <= '0;
            res.held    <= HW'(count);
            iss         <= '0;
            keep        <= '0;
            have        <= 1'b0;
            target      <= '{x: cmd.x, y: cmd.y, z: cmd.z};
            case (cmd.op)
              nplod_pkg::OP_ADD: begin
                res_push <= 1'b1;
                if (count < CNT_W'(MAX_POINTS)) begin
                  count    <= CNT_W'(count + 1'b1);
                  res.held <= HW'(count + 1'b1);
                end else begin
                  res.status <= nplod_pkg::ST_FULL;
                end
              end
              nplod_pkg::OP_REMOVE: begin
                state <= S_REMOVE;
              end
              nplod_pkg::OP_QUERY: begin
                if (count == '0) begin
                  res.status <= nplod_pkg::ST_EMPTY;
                  res_push   <= 1'b1;
                end else begin
                  state <= S_QUERY;
                end
              end
              default: begin
                res_push <= 1'b1;
              end
            endcase
          end
        end

        // compaction walk: survivors are rewritten at keep
        S_REMOVE: begin
          if (rd_v && (rd_data != target)) begin
            keep <= CNT_W'(keep + 1'b1);
          end
          if (!mem_re && !rd_v) begin
            count    <= keep;
            res.held <= HW'(keep);
            res_push <= 1'b1;
            state    <= S_IDLE;
          end
        end

        // walk the table through the distance pipeline
        S_QUERY: begin
          if (!mem_re && !rd_v && !va && !vb && !vc) begin
            div_start <= 1'b1;
            state     <= S_DIVIDE;
          end
        end

        S_DIVIDE: begin
          if (&div_done) begin
            res.scale_x <= div_x;
            res.scale_y <= div_y;
            res.scale_z <= div_z;
            res_push    <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-axis scale dividers
  nplod_div #(.DW(SQ_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bx),
    .divisor  (chunk_x),
    .done     (div_done[0]),
    .scale    (div_x)
  );

  nplod_div #(.DW(SQ_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (by),
    .divisor  (chunk_y),
    .done     (div_done[1]),
    .scale    (div_y)
  );

  nplod_div #(.DW(SQ_W)) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bz),
    .divisor  (chunk_z),
    .done     (div_done[2]),
    .scale    (div_z)
  );

endmodule

`default_nettype wire

// File: rtl/core/nplod_checker.sv
// ----------------------------------------------------------------------------
// nplod_checker
// Port-level checks on the result side of the scale unit.
// ----------------------------------------------------------------------------
`default_nettype none

module nplod_checker #(
  parameter int MAX_POINTS = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  empty,
  input logic                                  pop,
  input logic [nplod_pkg::STATUS_W-1:0]        status,
  input logic [nplod_pkg::SCALE_W-1:0]         scale_x,
  input logic [nplod_pkg::SCALE_W-1:0]         scale_y,
  input logic [nplod_pkg::SCALE_W-1:0]         scale_z,
  input logic [nplod_pkg::HELD_W-1:0]          points_held
);

  // reset flushes the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a full table report carries the table capacity
  a_full_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == nplod_pkg::ST_FULL) |->
      points_held == nplod_pkg::HELD_W'(MAX_POINTS))
    else $error("full status with wrong point count");

  // an empty table report carries no points
  a_empty_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == nplod_pkg::ST_EMPTY) |-> points_held == '0)
    else $error("no-points status with nonzero point count");

  // scales are zero on any non-ok result
  a_scale_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != nplod_pkg::ST_OK) |->
      (scale_x == '0 && scale_y == '0 && scale_z == '0))
    else $error("nonzero scale on failed transaction");

  // waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(scale_x) &&
      $stable(scale_y) && $stable(scale_z) && $stable(points_held)))
    else $error("pending result changed before pop");

endmodule

bind nearest_point_lod_scale_unit nplod_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (.*);

`default_nettype wire
